### design/assert_macros.svh
// Assertion macros shared by the box mean filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property sampled on the rising clock edge, off during reset
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error(msg);
// Same-cycle implication
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

### design/bmf_pkg.sv
// Package for the 7x7 box mean filter: widths, constants and types.
// No dependencies; used by the interfaces, the top level and bmf_cell.
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

    // Kernel geometry
    localparam int KSIZE = 7;
    localparam int KHALF = 3;
    localparam int KAREA = 49;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int PIX_MAX   = 255;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_POS_W = 10;
    localparam int COLSUM_W  = 11;   // 7 * 255 = 1785
    localparam int WINSUM_W  = 14;   // 49 * 255 = 12495

    // Register reset values
    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(512);

    // Divide by 49: floor(s * 21400 / 2^20) is exact for s < 43690
    localparam int DIV_MULT_W = 15;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(21400);
    localparam int DIV_SHIFT  = 20;

    // Line store word: six earlier rows of one column, oldest in the low byte
    localparam int LINE_W = (KSIZE - 1) * PIX_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0]    pixel_t;
    typedef logic [COLSUM_W-1:0] colsum_t;
    typedef logic [WINSUM_W-1:0] winsum_t;

    // Per-pixel tag carried down the pipeline
    typedef struct packed {
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 last;
        logic                 emit;
    } meta_t;

endpackage

`default_nettype wire

### design/bmf_pix_if.sv
// Pixel input channel: valid/ready handshake with pixel and frame_start.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmf_pix_if
    import bmf_pkg::*;
();
    logic       valid;
    logic       ready;
    pixel_t     pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

### design/bmf_res_if.sv
// Result channel: valid/ready handshake with mean value, position and last.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmf_res_if
    import bmf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    pixel_t               mean_value;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic                 last;

    modport source (output valid, output mean_value, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input mean_value, input out_row, input out_col,
                    input last, output ready);
endinterface

`default_nettype wire

### design/box_mean_filter_7x7_unit.sv
// 7x7 box mean filter, top level. An accepted pixel passes through the stage 1,
// stage 2, stage 3 and output registers before its result can be taken.
// Throughput: one pixel per clock while results.ready keeps the output free, set
// by the line store RAM doing one read and one write per cycle.
// Reset clears the position counters, the window cells and the running sum,
// and sets both dimensions to 512. The line store is not cleared; rows above
// row 0 of a frame read as zero.
// Depends on bmf_pkg, bmf_pix_if, bmf_res_if, bmf_ram, bmf_cell, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module box_mean_filter_7x7_unit
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    bmf_pix_if.sink                   pixels,
    bmf_res_if.source                 results
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WXW  = (CW > CFG_W ? CW : CFG_W) + 1;
    localparam int HXW  = (RW > CFG_W ? RW : CFG_W) + 1;
    localparam int CXW  = (CW > OUT_POS_W ? CW : OUT_POS_W);
    localparam int RXW  = (RW > OUT_POS_W ? RW : OUT_POS_W);
    localparam int PROD_W = WINSUM_W + DIV_MULT_W;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] img_width_reg;
    logic [CFG_W-1:0] img_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= DIM_RESET;
            img_height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_IMAGE_WIDTH:  img_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: img_height_reg <= cfg_data;
            endcase
        end
    end

    // Saturate dimensions and form the last column / row index
    logic [WXW-1:0] wid_ext;
    logic [HXW-1:0] hgt_ext;
    logic [CW-1:0]  w_last;
    logic [RW-1:0]  h_last;

    always_comb
    begin
        wid_ext = WXW'(img_width_reg);
        hgt_ext = HXW'(img_height_reg);
        if (wid_ext < WXW'(KSIZE))
            w_last = CW'(KSIZE - 1);
        else if (wid_ext > WXW'(MAX_WIDTH))
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(wid_ext - WXW'(1));
        if (hgt_ext < HXW'(KSIZE))
            h_last = RW'(KSIZE - 1);
        else if (hgt_ext > HXW'(MAX_HEIGHT))
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(hgt_ext - HXW'(1));
    end

    // ---------------- handshake chain ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, o_valid_reg;
    logic o_ready, s3_ready, s2_ready, s1_ready;
    logic s1_adv, s2_adv, pix_acc;

    assign o_ready  = !o_valid_reg || results.ready;
    assign s3_ready = !s3_valid_reg || o_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s2_adv   = s2_valid_reg && s3_ready;

    assign pixels.ready = s1_ready;
    assign pix_acc      = pixels.valid && s1_ready;

    // ---------------- position tracking ----------------
    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic [RW-1:0]    row_cnt_reg, row_cnt_next;
    logic [CW-1:0]    col_base, col_cur;
    logic [RW-1:0]    row_base, row_cur;
    logic [CXW-1:0]   col_x;
    logic [RXW-1:0]   row_x;
    logic             row_end, frame_end;
    meta_t            in_meta;
    logic [KSIZE-2:0] in_old_mask;

    always_comb
    begin
        col_base = pixels.frame_start ? '0 : col_cnt_reg;
        row_base = pixels.frame_start ? '0 : row_cnt_reg;
        col_cur  = (col_base > w_last) ? w_last : col_base;
        row_cur  = (row_base > h_last) ? h_last : row_base;
        row_end   = (col_cur == w_last);
        frame_end = row_end && (row_cur == h_last);

        // Centre position, three up and three left
        col_x = CXW'(col_cur) - CXW'(KHALF);
        row_x = RXW'(row_cur) - RXW'(KHALF);
        in_meta.row  = row_x[OUT_POS_W-1:0];
        in_meta.col  = col_x[OUT_POS_W-1:0];
        in_meta.last = frame_end;
        in_meta.emit = (row_cur >= RW'(KSIZE - 1)) && (col_cur >= CW'(KSIZE - 1));

        // Stored rows that lie above row 0 of this frame never reach a result
        for (int k = 0; k < KSIZE - 1; k++)
        begin
            in_old_mask[k] = (row_cur >= RW'(KSIZE - 1 - k));
        end

        if (frame_end)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (row_end)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_cur + RW'(1);
        end
        else
        begin
            col_cnt_next = col_cur + CW'(1);
            row_cnt_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- stage 1: line store read / shift-write ----------------
    logic [CW-1:0]     s1_col_reg;
    pixel_t            s1_px_reg;
    meta_t             s1_meta_reg;
    logic [KSIZE-2:0]  s1_old_mask_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [LINE_W-1:0] ram_rdata, line_raw, line_old, line_new;
    colsum_t           colsum;

    bmf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (line_new),
        .re    (pix_acc),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    // Column of seven pixels, oldest first; then the store shifts up one row
    always_comb
    begin
        line_raw = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        for (int r = 0; r < KSIZE - 1; r++)
        begin
            line_old[r*PIX_W +: PIX_W] = s1_old_mask_reg[r] ? line_raw[r*PIX_W +: PIX_W]
                                                            : '0;
        end
        line_new = {s1_px_reg, line_old[LINE_W-1:PIX_W]};
        colsum   = COLSUM_W'(s1_px_reg);
        for (int r = 0; r < KSIZE - 1; r++)
        begin
            colsum = colsum + COLSUM_W'(line_old[r*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pixels.valid;
            if (pix_acc)
            begin
                // Same column written this cycle: RAM returns the old word
                fwd_hit_reg <= s1_adv && (s1_col_reg == col_cur);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_col_reg      <= col_cur;
            s1_px_reg       <= pixels.pixel;
            s1_meta_reg     <= in_meta;
            s1_old_mask_reg <= in_old_mask;
            fwd_data_reg    <= line_new;
        end
    end

    // ---------------- stage 2: column sum register ----------------
    colsum_t s2_colsum_reg;
    meta_t   s2_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_colsum_reg <= colsum;
            s2_meta_reg   <= s1_meta_reg;
        end
    end

    // ---------------- window: row of column-sum cells ----------------
    colsum_t cell_sum [KSIZE];
    colsum_t cell_in  [KSIZE];

    for (genvar k = 0; k < KSIZE; k++)
    begin : g_cell
        if (k == KSIZE - 1)
        begin : g_head
            assign cell_in[k] = s2_colsum_reg;
        end
        else
        begin : g_body
            assign cell_in[k] = cell_sum[k + 1];
        end

        bmf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (s2_adv),
            .sum_in   (cell_in[k]),
            .sum_out  (cell_sum[k])
        );
    end

    // Running window sum: add the entering column, drop the leaving one
    winsum_t win_sum_reg, win_sum_next;

    always_comb
    begin
        win_sum_next = win_sum_reg - WINSUM_W'(cell_sum[0]) + WINSUM_W'(s2_colsum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_sum_reg <= '0;
        end
        else if (s2_adv)
        begin
            win_sum_reg <= win_sum_next;
        end
    end

    // ---------------- stage 3: window sum of an emitting pixel ----------------
    winsum_t s3_sum_reg;
    meta_t   s3_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg && s2_meta_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_sum_reg  <= win_sum_next;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // ---------------- output: divide by 49 via reciprocal ----------------
    logic [PROD_W-1:0] prod;
    pixel_t            o_mean_reg;
    meta_t             o_meta_reg;

    assign prod = PROD_W'(s3_sum_reg) * PROD_W'(DIV_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && s3_valid_reg)
        begin
            o_mean_reg <= prod[DIV_SHIFT +: PIX_W];
            o_meta_reg <= s3_meta_reg;
        end
    end

    assign results.valid      = o_valid_reg;
    assign results.mean_value = o_mean_reg;
    assign results.out_row    = o_meta_reg.row;
    assign results.out_col    = o_meta_reg.col;
    assign results.last       = o_meta_reg.last;

    // ---------------- checks ----------------
    winsum_t cells_total;

    always_comb
    begin
        cells_total = '0;
        for (int k = 0; k < KSIZE; k++)
        begin
            cells_total = cells_total + WINSUM_W'(cell_sum[k]);
        end
    end

    // Running sum must track the cells exactly
    `ASSERT_CLK(a_win_sum_match, clk, rst_n, win_sum_reg == cells_total,
                "running window sum differs from cell contents")
    // A pending window sum never exceeds 49 full-scale pixels
    `ASSERT_IMPL(a_sum_range, clk, rst_n, s3_valid_reg,
                 s3_sum_reg <= WINSUM_W'(KAREA * PIX_MAX), "window sum out of range")
    // Taking a pixel while stage 1 is full means stage 1 writes back this cycle
    `ASSERT_IMPL(a_s1_drains, clk, rst_n, pix_acc && s1_valid_reg, s1_adv,
                 "pixel accepted over a stalled line store update")

endmodule

`default_nettype wire

### design/bmf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/bmf_cell.sv
// One window column cell: holds the sum of a 7-pixel column and passes it
// to its left neighbor on every shift. Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmf_cell
    import bmf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    shift_en,
    input  wire colsum_t sum_in,
    output colsum_t      sum_out
);

    colsum_t sum_reg;
    colsum_t sum_next;

    // Load from the right neighbor on a shift
    always_comb
    begin
        sum_next = shift_en ? sum_in : sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire
